/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define SSTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the same cycle.
`define SSTC_IMPLY(label, ante, cons, msg) \
  `SSTC_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/sstc_pkg.sv */
package sstc_pkg;

  localparam int MAX_STEPS  = 16;
  localparam int MAX_VOICES = 16;
  localparam int STEP_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam int MIN_W      = 25;
  localparam int DIV_W      = 13;
  localparam int MINUTE_SECS = 60;
  localparam int HOLDOFF_BLOCKS = 32;

  localparam logic signed [24:0] CNT_MIN = -25'sd8388608;
  localparam logic signed [25:0] CNT_MAX = 26'sd8388607;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_SELECT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH   = 3'd5;

  localparam logic ACT_BLOCK = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic       action;
    logic       trigger_seen;
    logic       voice_found;
    logic [3:0] voice_index;
    logic [3:0] step_index;
    logic [6:0] step_pitch;
    logic       step_gate;
    logic [6:0] step_velocity;
  } in_item_t;

  typedef struct packed {
    logic       gate_out;
    logic [6:0] pitch_sum;
    logic [6:0] velocity_out;
    logic [3:0] voice_out;
    logic       start_marker;
  } out_item_t;

  typedef struct packed {
    logic [6:0] pitch;
    logic       gate;
    logic [6:0] velocity;
  } step_entry_t;

  localparam int ENTRY_W = $bits(step_entry_t);
  localparam step_entry_t ENTRY_RESET = '{pitch: 7'd31, gate: 1'b0, velocity: 7'd63};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

endpackage

/* rtl/sstc_ram.sv */
module sstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sstc_divider.sv */
module sstc_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sstc_pkg::MIN_W-1:0] dividend,
  input  logic [sstc_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [sstc_pkg::MIN_W-1:0] quotient,
  output logic [sstc_pkg::DIV_W-1:0] remainder
);
  import sstc_pkg::*;

  localparam int CNT_W = $clog2(MIN_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] div_reg;
  logic [DIV_W-1:0] rem_acc;
  logic [MIN_W-1:0] quo;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem_acc, quo[MIN_W-1]};
  assign fits  = trial >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(MIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit is settled per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      div_reg <= divisor;
      rem_acc <= '0;
      quo     <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem_acc <= DIV_W'(trial - {1'b0, div_reg});
        quo     <= {quo[MIN_W-2:0], 1'b1};
      end else begin
        rem_acc <= trial[DIV_W-1:0];
        quo     <= {quo[MIN_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem_acc;

endmodule

/* rtl/step_sequencer_tempo_clock.sv */
// Step sequencer with a tempo clock. Each beat on the input channel is either one audio
// block, which always yields exactly one result beat, or a write to one step of the
// pitch, gate and velocity tables, which yields none. A write is taken in the idle state.
// A block without a tick passes from calc straight to finish; a block that ticks starts
// the bit-serial divider, which works out the frames to the next tick, one quotient bit
// per cycle over 25 bits, and applies its result before finish. A stalled result beat
// holds the block for as long as it waits. The step tables live in a 16-entry RAM with
// registered read; after reset every entry reads as its default until first written.
// The configuration port is always ready and must only be written while the block is idle.
module step_sequencer_tempo_clock (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sstc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sstc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sstc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sstc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sstc_pkg::*;

  `include "assert_macros.svh"

  state_t state, state_next;

  logic [17:0] sample_rate;
  logic [12:0] block_frames;
  logic [8:0]  tempo_bpm;
  logic [5:0]  pitch_offset;
  logic [1:0]  gate_select;
  logic [4:0]  seq_length;

  logic signed [23:0] frames_to_tick;
  logic [DIV_W-1:0]   tempo_remainder;
  logic               restart_pending;
  logic [5:0]         holdoff_count;
  logic [1:0]         sub_tick;
  logic [STEP_W-1:0]  step_position;
  logic               gate_level;
  logic [6:0]         pitch_level;
  logic [6:0]         velocity_level;
  logic [3:0]         active_voice;
  logic               start_flag;
  logic [MAX_STEPS-1:0] entry_valid;

  logic       voice_found_q;
  logic [3:0] voice_index_q;
  logic       rd_valid;

  logic in_accept, block_accept, write_accept, write_in_range;
  logic div_start, div_done, ram_re, load_out, tick_due;

  logic [MIN_W-1:0] div_quotient;
  logic [DIV_W-1:0] div_remainder;
  logic [MIN_W-1:0] minute;
  logic [DIV_W-1:0] divisor;
  logic [8:0]       bpm_eff;

  logic [ENTRY_W-1:0] ram_rd_data;
  step_entry_t        wr_entry, entry;
  logic [STEP_W-1:0]  rd_addr, pos_cur, pos_next;
  logic [1:0]         sub_cur;
  logic [5:0]         pos_inc, seq_eff, seq_ext;
  logic [7:0]         pitch_wide;
  logic [6:0]         pitch_sat;
  logic [2:0]         gate_len;
  logic               voice_ok;

  logic signed [24:0] frames_dec, frames_dec_sat;
  logic signed [25:0] frames_inc;
  logic signed [23:0] frames_inc_sat;

  assign cfg_ready    = 1'b1;
  assign in_accept    = in_valid && !in_stall;
  assign block_accept = in_accept && (in_data.action == ACT_BLOCK);
  assign write_accept = in_accept && (in_data.action == ACT_WRITE);
  assign write_in_range = int'(in_data.step_index) < MAX_STEPS;

  assign tick_due = frames_to_tick[23] || (frames_to_tick == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    ram_re     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.action == ACT_BLOCK)) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (tick_due) begin
          div_start  = 1'b1;
          ram_re     = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= 18'd44100;
      block_frames <= 13'd64;
      tempo_bpm    <= 9'd120;
      pitch_offset <= 6'd32;
      gate_select  <= 2'd0;
      seq_length   <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate  <= cfg_data[17:0];
        REG_BLOCK_FRAMES: block_frames <= cfg_data[12:0];
        REG_TEMPO_BPM:    tempo_bpm    <= cfg_data[8:0];
        REG_PITCH_OFFSET: pitch_offset <= cfg_data[5:0];
        REG_GATE_SELECT:  gate_select  <= cfg_data[1:0];
        REG_SEQ_LENGTH:   seq_length   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign wr_entry = '{pitch: in_data.step_pitch, gate: in_data.step_gate,
                      velocity: in_data.step_velocity};

  sstc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STEPS)
  ) u_step_ram (
    .clk     (clk),
    .we      (write_accept && write_in_range),
    .wr_addr (STEP_W'(in_data.step_index)),
    .wr_data (wr_entry),
    .re      (ram_re),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign bpm_eff = (tempo_bpm == '0) ? 9'd1 : tempo_bpm;
  assign divisor = {bpm_eff, 4'b0000};
  assign minute  = MIN_W'(sample_rate) * MIN_W'(MINUTE_SECS) + MIN_W'(tempo_remainder);

  sstc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (minute),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  assign frames_dec = {frames_to_tick[23], frames_to_tick} - $signed({12'b0, block_frames});
  assign frames_dec_sat = (frames_dec < CNT_MIN) ? CNT_MIN : frames_dec;
  assign frames_inc = {{2{frames_to_tick[23]}}, frames_to_tick} + $signed({1'b0, div_quotient});
  assign frames_inc_sat = (frames_inc > CNT_MAX) ? 24'sd8388607 : frames_inc[23:0];

  // A restart raised by this block already applies to its tick.
  assign pos_cur = restart_pending ? '0 : step_position;
  assign sub_cur = restart_pending ? 2'd0 : sub_tick;
  assign rd_addr = pos_cur;

  assign entry      = rd_valid ? step_entry_t'(ram_rd_data) : ENTRY_RESET;
  assign pitch_wide = {1'b0, entry.pitch} + {2'b00, pitch_offset};
  assign pitch_sat  = pitch_wide[7] ? 7'd127 : pitch_wide[6:0];
  assign gate_len   = 3'd4 - {1'b0, gate_select};
  assign voice_ok   = voice_found_q && (int'(voice_index_q) < MAX_VOICES);

  assign seq_ext  = {1'b0, seq_length};
  assign seq_eff  = (seq_ext > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : seq_ext;
  assign pos_inc  = 6'(pos_cur) + 6'd1;
  assign pos_next = (pos_inc >= seq_eff) ? '0 : STEP_W'(pos_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_tick  <= '0;
      tempo_remainder <= '0;
      restart_pending <= 1'b0;
      holdoff_count   <= '0;
      sub_tick        <= '0;
      step_position   <= '0;
      gate_level      <= 1'b0;
      pitch_level     <= '0;
      velocity_level  <= '0;
      active_voice    <= '0;
      start_flag      <= 1'b0;
      entry_valid     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (block_accept) begin
        if (holdoff_count != '0) begin
          holdoff_count <= holdoff_count - 1'b1;
        end else if (in_data.trigger_seen && !restart_pending) begin
          restart_pending <= 1'b1;
          holdoff_count   <= 6'(HOLDOFF_BLOCKS);
        end
        frames_to_tick <= frames_dec_sat[23:0];
      end
      if (write_accept && write_in_range) begin
        entry_valid[STEP_W'(in_data.step_index)] <= 1'b1;
      end
      if (state == ST_APPLY) begin
        frames_to_tick  <= frames_inc_sat;
        tempo_remainder <= div_remainder;
        restart_pending <= 1'b0;
        start_flag      <= (pos_cur == '0);
        if (sub_cur == 2'd0) begin
          pitch_level    <= pitch_sat;
          velocity_level <= entry.velocity;
          active_voice   <= voice_ok ? voice_index_q : 4'd0;
          gate_level     <= voice_ok && entry.gate;
          step_position  <= pos_next;
        end
        if ({1'b0, sub_cur} == gate_len) begin
          gate_level <= 1'b0;
        end
        sub_tick <= sub_cur + 2'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (block_accept) begin
      voice_found_q <= in_data.voice_found;
      voice_index_q <= in_data.voice_index;
    end
    if (ram_re) begin
      rd_valid <= entry_valid[rd_addr];
    end
    if (load_out) begin
      out_data <= '{gate_out: gate_level, pitch_sum: pitch_level,
                    velocity_out: velocity_level, voice_out: active_voice,
                    start_marker: start_flag};
    end
  end

  `SSTC_IMPLY(a_out_from_fin, $rose(out_valid), $past(state == ST_FIN), "result outside finish")
  `SSTC_IMPLY(a_div_done_in_wait, div_done, state == ST_DIV, "divider done while not awaited")
  `SSTC_ASSERT(a_holdoff_range, holdoff_count <= 6'(HOLDOFF_BLOCKS), "holdoff out of range")
  `SSTC_IMPLY(a_restart_holdoff, $rose(restart_pending), holdoff_count == 6'(HOLDOFF_BLOCKS), "short holdoff")

endmodule
